### sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge, suppressed while reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// checked at every rising edge, reset included
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

### sv/oaat_pkg.sv
package oaat_pkg;

   localparam int unsigned HASH_W = 32;
   localparam int unsigned BYTE_W = 8;

   localparam logic [HASH_W-1:0] SEED_RESET = 32'h3FAC7125;

   typedef logic [HASH_W-1:0] hash_type;
   typedef logic [BYTE_W-1:0] byte_type;

   // per-transaction control handed to the accumulator
   typedef struct packed {
      logic fire;
      logic last;
   } step_type;

   // byte add (sign-extended) followed by the per-byte mix
   function automatic hash_type mix_byte(input hash_type h, input byte_type b);
      hash_type ext;
      hash_type t;
      ext = {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
      t = h + ext;
      t = t + (t << 10);
      t = t ^ (t >> 6);
      return t;
   endfunction

   function automatic hash_type final_mix(input hash_type h);
      hash_type t;
      t = h + (h << 3);
      t = t ^ (t >> 11);
      t = t + (t << 15);
      return t;
   endfunction

endpackage

### sv/oaat_accum.sv
module oaat_accum (
   input  logic              clock,
   input  logic              reset,
   input  oaat_pkg::step_type step,
   input  oaat_pkg::byte_type byte_in,
   input  oaat_pkg::hash_type seed,
   output oaat_pkg::hash_type mixed
);
   import oaat_pkg::*;

   hash_type running_ff;
   hash_type running_in;
   logic     in_message_ff;
   logic     in_message_in;
   hash_type start;

   // a new message starts from the seed as it stands at its first byte
   assign start = in_message_ff ? running_ff : seed;
   assign mixed = mix_byte(start, byte_in);

   always_comb begin
      running_in    = running_ff;
      in_message_in = in_message_ff;
      if (step.fire) begin
         running_in    = mixed;
         in_message_in = !step.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_message_ff <= 1'b0;
      end else begin
         in_message_ff <= in_message_in;
      end
   end

   always_ff @(posedge clock) begin
      running_ff <= running_in;
   end

endmodule

### sv/one_at_a_time_hash_stream.sv
// One-at-a-time hash over a byte stream.
// req channel: one message byte per transaction, req_tlast marks the final
// byte of a message; every message has at least that one byte.
// rsp channel: one 32-bit hash per message, after its last byte.
// csr port: csr_we loads csr_wdata into the seed at the clock edge; the seed
// is sampled at the first byte of each message, so write it between messages.
// Throughput: one byte per cycle unless a stalled receiver backs up the
// pipeline, set by the combinational running-hash update (byte add and mix).
// A last byte passes the input register, then takes the byte mix into the
// middle stage and the final mix into the output register, where
// rsp_tvalid rises.
// Reset clears all valid flags, restores the seed to 0x3FAC7125 and starts a
// fresh message.
// When the receiver stalls, the finished hash holds in the output register,
// one more hash waits in the middle stage, and bytes keep flowing until a
// third last byte needs a slot; only then does req_tready drop.
`include "assert_macros.svh"

module one_at_a_time_hash_stream (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] byte_in
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // [31:0] hash_out
   input  logic                 csr_we,
   input  oaat_pkg::hash_type   csr_wdata
);
   import oaat_pkg::*;

   hash_type seed_ff;
   hash_type seed_in;

   logic     s1_valid_ff, s1_valid_in;
   byte_type s1_byte_ff, s1_byte_in;
   logic     s1_last_ff, s1_last_in;

   logic     s2_valid_ff, s2_valid_in;
   hash_type s2_hash_ff, s2_hash_in;

   logic     out_valid_ff, out_valid_in;
   hash_type out_hash_ff, out_hash_in;

   logic     req_fire;
   logic     out_free;
   logic     s2_free;
   logic     s2_fire;
   logic     s1_fire;
   step_type step;
   hash_type mixed;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign s2_fire    = s2_valid_ff && out_free;
   assign s2_free    = !s2_valid_ff || out_free;
   // bytes without last only update the running hash and never wait
   assign s1_fire    = s1_valid_ff && (!s1_last_ff || s2_free);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   assign step.fire = s1_fire;
   assign step.last = s1_last_ff;

   oaat_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .byte_in (s1_byte_ff),
      .seed    (seed_ff),
      .mixed   (mixed)
   );

   always_comb begin
      seed_in = csr_we ? csr_wdata : seed_ff;

      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_last_in  = s1_last_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_tdata;
         s1_last_in  = req_tlast;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in = s2_valid_ff;
      s2_hash_in  = s2_hash_ff;
      if (s1_fire && s1_last_ff) begin
         s2_valid_in = 1'b1;
         s2_hash_in  = mixed;
      end else if (s2_fire) begin
         s2_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_hash_in  = out_hash_ff;
      if (s2_fire) begin
         out_valid_in = 1'b1;
         out_hash_in  = final_mix(s2_hash_ff);
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= SEED_RESET;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff  <= s1_byte_in;
      s1_last_ff  <= s1_last_in;
      s2_hash_ff  <= s2_hash_in;
      out_hash_ff <= out_hash_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_hash_ff;

   // first edge after reset is released
   `ASSERT_CLK(a_idle_after_reset, clock, $past(reset) && !reset |-> !rsp_tvalid && req_tready)
   `ASSERT_CLK_RST(a_last_reaches_s2, clock, reset, s1_fire && s1_last_ff |=> s2_valid_ff)
   `ASSERT_CLK_RST(a_final_mix_out, clock, reset,
      s2_fire |=> rsp_tvalid && rsp_tdata == final_mix($past(s2_hash_ff)))

endmodule
